### src/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define TSA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsa assertion failed");

// clocked assertion that also holds during reset
`define TSA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tsa assertion failed");

`endif

### src/tsa_pkg.sv
package tsa_pkg;

  // field widths
  localparam int MODE_W        = 2;
  localparam int PERIOD_W      = 26;
  localparam int NUM_W         = 32;
  localparam int SPEED_W       = 12;
  localparam int TIMEOUT_W     = 8;
  localparam int SEC_W         = 32;
  localparam int FRACTION_BITS = 4;
  localparam int RING_DEPTH    = 64;

  // derived widths
  localparam int RPM_W      = SPEED_W + FRACTION_BITS;
  localparam int SUM_W      = RPM_W + $clog2(RING_DEPTH);
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int DVD_W      = NUM_W + FRACTION_BITS;
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [NUM_W-1:0]     NUM_RESET     = 32'd90000000;
  localparam logic [SPEED_W-1:0]   MAX_RESET     = 12'd4000;
  localparam logic [SPEED_W-1:0]   START_RESET   = 12'd275;
  localparam logic [SPEED_W-1:0]   STOP_RESET    = 12'd225;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd2;
  localparam logic [SEC_W-1:0]     BASE_RESET    = 32'd7016400;
  localparam logic [TIMEOUT_W-1:0] EXPIRY_MAX    = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CAPTURE = 2'd0,
    MODE_EXPIRE  = 2'd1,
    MODE_EVAL    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMERATOR = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_START     = 3'd2,
    REG_STOP      = 3'd3,
    REG_TIMEOUT   = 3'd4,
    REG_BASE_SECS = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_EXPIRE,
    ST_EVAL_MEAN,
    ST_EVAL_RUN,
    ST_EVAL_TIME,
    ST_OUT
  } state_e;

endpackage

### src/tsa_if.sv
// input word channel
interface tsa_in_if import tsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PERIOD_W-1:0] period_count;
  logic [SEC_W-1:0]    now_seconds;

  modport source (output valid, mode, period_count, now_seconds, input ready);
  modport sink (input valid, mode, period_count, now_seconds, output ready);
endinterface

// result word channel
interface tsa_out_if import tsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] speed_q4;
  logic             running;
  logic [SEC_W-1:0] engine_seconds;
  logic             history_cleared;

  modport source (output valid, speed_q4, running, engine_seconds, history_cleared,
                  input ready);
  modport sink (input valid, speed_q4, running, engine_seconds, history_cleared,
                output ready);
endinterface

### src/tsa_ram.sv
module tsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/tach_speed_averager_run_timer.sv
// channel | dir | payload
// in_i    | in  | mode, period_count, now_seconds
// out_o   | out | speed_q4, running, engine_seconds, history_cleared
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// one word at a time: ready is high only while the block is idle
// capture: accept, divider steps, ring update, output; a zero period skips to output
// the serial restoring divider (one quotient bit a cycle) sets the capture time
// expiry uses ST_EXPIRE, evaluate the ST_EVAL states, an unused mode none, then output wait
// the result holds until taken; reset restores the block state, clears ring valid bits
module tach_speed_averager_run_timer import tsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsa_in_if.sink                in_i,
  tsa_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  // configuration
  logic [NUM_W-1:0]     numerator_q, numerator_d;
  logic [SPEED_W-1:0]   max_speed_q, max_speed_d;
  logic [SPEED_W-1:0]   start_speed_q, start_speed_d;
  logic [SPEED_W-1:0]   stop_speed_q, stop_speed_d;
  logic [TIMEOUT_W-1:0] timeout_q, timeout_d;

  // block state
  logic [SUM_W-1:0]      ring_sum_q, ring_sum_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [RING_DEPTH-1:0] ring_valid_q, ring_valid_d;
  logic [TIMEOUT_W-1:0]  expiry_q, expiry_d;
  logic [RPM_W-1:0]      mean_q, mean_d;
  logic                  run_q, run_d;
  logic [SEC_W-1:0]      start_q, start_d;
  logic [SEC_W-1:0]      total_q, total_d;
  logic [SEC_W-1:0]      shown_q, shown_d;
  logic                  cleared_q, cleared_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;

  // word and datapath registers
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [SEC_W-1:0]    now_q, now_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]    quo_q, quo_d;
  logic [SEC_W-1:0]    elapsed_q, elapsed_d;
  logic                stop_pend_q, stop_pend_d;

  // ring memory
  logic             ram_we;
  logic [RPM_W-1:0] ram_rdata;
  logic [RPM_W-1:0] rpm;

  // shared datapath terms
  logic [PERIOD_W:0]    rem_shift;
  logic [PERIOD_W:0]    rem_diff;
  logic                 rpm_ok;
  logic [RPM_W-1:0]     old_entry;
  logic [RPM_W-1:0]     mean_cand;
  logic [RPM_W-1:0]     max_bound;
  logic [RPM_W-1:0]     start_bound;
  logic [RPM_W-1:0]     stop_bound;
  logic [TIMEOUT_W-1:0] expiry_inc;
  logic [SEC_W-1:0]     time_sum;
  logic                 in_acc;

  assign in_acc = in_i.valid && in_i.ready;

  // restoring divider step: one quotient bit a cycle
  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, period_q};

  assign max_bound   = RPM_W'(max_speed_q) << FRACTION_BITS;
  assign start_bound = RPM_W'(start_speed_q) << FRACTION_BITS;
  assign stop_bound  = RPM_W'(stop_speed_q) << FRACTION_BITS;
  assign rpm_ok      = (quo_q != '0) && (quo_q < (DVD_W'(max_speed_q) << FRACTION_BITS));
  assign rpm         = quo_q[RPM_W-1:0];
  assign old_entry   = ring_valid_q[slot_q] ? ram_rdata : '0;
  assign mean_cand   = RPM_W'(ring_sum_q / RING_DEPTH);
  assign expiry_inc  = (expiry_q == EXPIRY_MAX) ? expiry_q : expiry_q + 1'b1;
  assign time_sum    = total_q + elapsed_q;

  // ring entries, read address follows the write slot
  tsa_ram #(
    .WIDTH(RPM_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(rpm),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  // sequencer and datapath next values
  always_comb begin
    state_d       = state_q;
    numerator_d   = numerator_q;
    max_speed_d   = max_speed_q;
    start_speed_d = start_speed_q;
    stop_speed_d  = stop_speed_q;
    timeout_d     = timeout_q;
    ring_sum_d    = ring_sum_q;
    slot_d        = slot_q;
    ring_valid_d  = ring_valid_q;
    expiry_d      = expiry_q;
    mean_d        = mean_q;
    run_d         = run_q;
    start_d       = start_q;
    total_d       = total_q;
    shown_d       = shown_q;
    cleared_d     = cleared_q;
    cnt_d         = cnt_q;
    period_d      = period_q;
    now_d         = now_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    elapsed_d     = elapsed_q;
    stop_pend_d   = stop_pend_q;
    ram_we        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          period_d  = in_i.period_count;
          now_d     = in_i.now_seconds;
          cleared_d = 1'b0;
          case (mode_e'(in_i.mode))
            MODE_CAPTURE: begin
              expiry_d = '0;
              rem_d    = '0;
              quo_d    = DVD_W'(numerator_q) << FRACTION_BITS;
              cnt_d    = DIV_CNT_W'(DIV_STEPS - 1);
              state_d  = (in_i.period_count == '0) ? ST_OUT : ST_DIV;
            end
            MODE_EXPIRE: state_d = ST_EXPIRE;
            MODE_EVAL:   state_d = ST_EVAL_MEAN;
            default:     state_d = ST_OUT;
          endcase
        end
      end
      ST_DIV: begin
        if (!rem_diff[PERIOD_W]) begin
          rem_d = rem_diff[PERIOD_W-1:0];
          quo_d = {quo_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[PERIOD_W-1:0];
          quo_d = {quo_q[DVD_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_UPDATE;
        end
      end
      // if the speed is in range, replace the oldest entry and keep the running sum
      ST_UPDATE: begin
        if (rpm_ok) begin
          ram_we               = 1'b1;
          ring_sum_d           = ring_sum_q - SUM_W'(old_entry) + SUM_W'(rpm);
          ring_valid_d[slot_q] = 1'b1;
          slot_d = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        end
        state_d = ST_OUT;
      end
      // window expiry, clear history once past the limit while moving
      ST_EXPIRE: begin
        expiry_d = expiry_inc;
        if (expiry_inc > timeout_q && mean_q != '0) begin
          ring_valid_d = '0;
          ring_sum_d   = '0;
          cleared_d    = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_EVAL_MEAN: begin
        if (mean_cand < max_bound) begin
          mean_d = mean_cand;
        end
        state_d = ST_EVAL_RUN;
      end
      // start and stop hysteresis
      ST_EVAL_RUN: begin
        stop_pend_d = 1'b0;
        if (!run_q && mean_q > start_bound) begin
          start_d   = now_q;
          run_d     = 1'b1;
          elapsed_d = '0;
        end else begin
          elapsed_d   = now_q - start_q;
          stop_pend_d = run_q && (mean_q < stop_bound);
        end
        state_d = ST_EVAL_TIME;
      end
      ST_EVAL_TIME: begin
        if (run_q) begin
          shown_d = time_sum;
        end
        if (stop_pend_q) begin
          total_d = time_sum;
          run_d   = 1'b0;
          start_d = '0;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // register writes, to be issued only while idle; the block does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_NUMERATOR: numerator_d   = cfg_data_i[NUM_W-1:0];
        REG_MAX_SPEED: max_speed_d   = cfg_data_i[SPEED_W-1:0];
        REG_START:     start_speed_d = cfg_data_i[SPEED_W-1:0];
        REG_STOP:      stop_speed_d  = cfg_data_i[SPEED_W-1:0];
        REG_TIMEOUT:   timeout_d     = cfg_data_i[TIMEOUT_W-1:0];
        REG_BASE_SECS: begin
          total_d = cfg_data_i[SEC_W-1:0];
          shown_d = cfg_data_i[SEC_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q   <= NUM_RESET;
      max_speed_q   <= MAX_RESET;
      start_speed_q <= START_RESET;
      stop_speed_q  <= STOP_RESET;
      timeout_q     <= TIMEOUT_RESET;
      ring_sum_q    <= '0;
      slot_q        <= '0;
      ring_valid_q  <= '0;
      expiry_q      <= '0;
      mean_q        <= '0;
      run_q         <= 1'b0;
      start_q       <= '0;
      total_q       <= BASE_RESET;
      shown_q       <= BASE_RESET;
      cleared_q     <= 1'b0;
      cnt_q         <= '0;
    end else begin
      numerator_q   <= numerator_d;
      max_speed_q   <= max_speed_d;
      start_speed_q <= start_speed_d;
      stop_speed_q  <= stop_speed_d;
      timeout_q     <= timeout_d;
      ring_sum_q    <= ring_sum_d;
      slot_q        <= slot_d;
      ring_valid_q  <= ring_valid_d;
      expiry_q      <= expiry_d;
      mean_q        <= mean_d;
      run_q         <= run_d;
      start_q       <= start_d;
      total_q       <= total_d;
      shown_q       <= shown_d;
      cleared_q     <= cleared_d;
      cnt_q         <= cnt_d;
    end
  end

  // word and divider payload
  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    now_q       <= now_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    elapsed_q   <= elapsed_d;
    stop_pend_q <= stop_pend_d;
  end

  // handshake and result word
  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = (state_q == ST_OUT);
  assign out_o.speed_q4        = mean_q;
  assign out_o.running         = run_q;
  assign out_o.engine_seconds  = shown_q;
  assign out_o.history_cleared = cleared_q;

endmodule

### src/tsa_checker.sv
`include "assert_macros.svh"

module tsa_checker import tsa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [RPM_W-1:0] out_speed_q4_i,
  input logic             out_running_i,
  input logic [SEC_W-1:0] out_engine_seconds_i,
  input logic             out_history_cleared_i
);

  // one word in flight: busy right after taking a word
  `TSA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)

  // no new word while a result waits
  `TSA_ASSERT(a_no_take_while_pending, clk_i, rst_ni, out_valid_i |-> !in_ready_i)

  // a stalled result holds
  `TSA_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_speed_q4_i) && $stable(out_running_i) && $stable(out_engine_seconds_i) && $stable(out_history_cleared_i))

  // history is only cleared while the averaged speed is above zero
  `TSA_ASSERT(a_clear_needs_speed, clk_i, rst_ni, out_valid_i && out_history_cleared_i |-> out_speed_q4_i != '0)

endmodule

bind tach_speed_averager_run_timer tsa_checker u_tsa_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_speed_q4_i       (out_o.speed_q4),
  .out_running_i        (out_o.running),
  .out_engine_seconds_i (out_o.engine_seconds),
  .out_history_cleared_i(out_o.history_cleared)
);
